FILE: rtl/bm25_pkg.sv
// Types and constants shared by the BM25 document scorer.
`default_nettype none
package bm25_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LNORM,
    S_LSQ,
    S_IDF,
    S_KA,
    S_KB,
    S_KC,
    S_KD,
    S_KDIV,
    S_TFM,
    S_TDIV,
    S_QM,
    S_QDIV,
    S_T1,
    S_T2,
    S_ACC
  } state_t;

  typedef enum logic [2:0] {
    REG_NUM_DOCS = 3'd0,
    REG_AVG_LEN  = 3'd1,
    REG_K1       = 3'd2,
    REG_B        = 3'd3,
    REG_K3       = 3'd4
  } cfg_reg_t;

  localparam int unsigned LOG_FRAC   = 20;
  localparam int unsigned LOG_ITERS  = 20;
  localparam int unsigned DIV_STEPS  = 64;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [39:0] SUM_MAX    = 40'hFF_FFFF_FFFF;
  localparam logic [12:0] B_ONE      = 13'd4096;
  localparam logic [14:0] K1_ONE     = 15'd4096;

  localparam logic [23:0] NUM_DOCS_RST = 24'd1;
  localparam logic [31:0] AVG_LEN_RST  = 32'd256;
  localparam logic [13:0] K1_RST       = 14'd6144;
  localparam logic [12:0] B_RST        = 13'd3072;
  localparam logic [15:0] K3_RST       = 16'd500;

endpackage
`default_nettype wire

FILE: rtl/bm25_document_scorer_top.sv
// Okapi BM25 document scorer: sequenced datapath around one shared multiplier and divider.
//
//   channel | direction | signals
//   in      | input     | in_valid, in_stall, term_freq, doc_freq, query_term_freq,
//           |           | doc_length, last_term
//   out     | output    | out_valid, out_stall, score, saturated
//   cfg     | input     | cfg_we, cfg_index, cfg_data
//
// Each term occupies the block from its transfer until it is accumulated: two 20-step logs,
// then three 64-step divisions; a zero term frequency or a zero k3 plus query
// frequency skips one division each. Reset loads the default configuration and clears
// the accumulator; a held output stall only delays the final term of a document.
`default_nettype none
module bm25_document_scorer_top #(
  parameter int SCORE_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] term_freq,
  input  wire logic [23:0] doc_freq,
  input  wire logic [15:0] query_term_freq,
  input  wire logic [23:0] doc_length,
  input  wire logic        last_term,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [39:0]      score,
  output logic             saturated
);

  localparam int TERM_SHIFT = 32 - SCORE_FRAC_BITS;

  bm25_pkg::state_t state, state_next;

  logic [23:0] num_docs;
  logic [31:0] avg_doc_length;
  logic [13:0] k1_gain;
  logic [12:0] b_norm;
  logic [15:0] k3_gain;

  logic [15:0] tf;
  logic [23:0] df;
  logic [15:0] qtf;
  logic [23:0] dl;
  logic        last;

  logic [25:0] lv;
  logic [30:0] lm;
  logic [19:0] frac;
  logic [4:0]  lexp;
  logic        second;
  logic [24:0] la;
  logic [24:0] lb;
  logic [24:0] idf;
  logic [45:0] s;
  logic [63:0] dvd;
  logic [52:0] rem;
  logic [52:0] dsr;
  logic [5:0]  cnt;
  logic [18:0] tfq;
  logic [32:0] qtfq;
  logic [23:0] t;
  logic [48:0] term;
  logic [39:0] score_sum;
  logic        sum_clipped;

  logic [31:0] avg_e;
  logic [12:0] b_e;
  logic [32:0] mul_a;
  logic [32:0] mul_b;
  logic [65:0] mul_p;
  logic [4:0]  lv_msb;
  logic [31:0] sq;
  logic        sq_top;
  logic [19:0] frac_next;
  logic [53:0] rem_sh;
  logic        div_ge;
  logic [53:0] div_diff;
  logic        log_done;
  logic        div_done;
  logic        qz;
  logic        out_take;
  logic        out_load;
  logic [39:0] room;
  logic [23:0] df_in;

  assign avg_e = (avg_doc_length == 32'd0) ? 32'd1 : avg_doc_length;
  assign b_e   = (b_norm > bm25_pkg::B_ONE) ? bm25_pkg::B_ONE : b_norm;
  assign mul_p = 66'(mul_a) * 66'(mul_b);
  assign sq        = mul_p[61:30];
  assign sq_top    = sq[31];
  assign frac_next = {frac[18:0], sq_top};
  assign rem_sh    = {rem, dvd[63]};
  assign div_diff  = rem_sh - {1'b0, dsr};
  assign div_ge    = (rem_sh >= {1'b0, dsr});
  assign log_done  = (cnt == 6'(bm25_pkg::LOG_ITERS - 1));
  assign div_done  = (cnt == 6'(bm25_pkg::DIV_STEPS - 1));
  assign qz        = ((17'(k3_gain) + 17'(qtf)) == 17'd0);
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == bm25_pkg::S_ACC) && last && (!out_valid || !out_stall);
  assign room      = bm25_pkg::SUM_MAX - score_sum;
  assign df_in     = (doc_freq > num_docs) ? num_docs : doc_freq;

  always_comb begin
    lv_msb = 5'd0;
    for (int i = 0; i < 26; i++) begin
      if (lv[i]) begin
        lv_msb = 5'(i);
      end
    end
  end

  always_comb begin
    mul_a = 33'd0;
    mul_b = 33'd0;
    case (state)
      bm25_pkg::S_LSQ: begin
        mul_a = 33'(lm);
        mul_b = 33'(lm);
      end
      bm25_pkg::S_IDF: begin
        mul_a = 33'(la - lb);
        mul_b = 33'(bm25_pkg::LN2_Q32);
      end
      bm25_pkg::S_KA: begin
        mul_a = 33'(bm25_pkg::B_ONE - b_e);
        mul_b = 33'(avg_e);
      end
      bm25_pkg::S_KB: begin
        mul_a = 33'(b_e);
        mul_b = 33'(dl);
      end
      bm25_pkg::S_KC: begin
        mul_a = 33'(k1_gain);
        mul_b = 33'(s[45:32]);
      end
      bm25_pkg::S_KD: begin
        mul_a = 33'(k1_gain);
        mul_b = 33'(s[31:0]);
      end
      bm25_pkg::S_TFM: begin
        mul_a = 33'(15'(k1_gain) + bm25_pkg::K1_ONE);
        mul_b = 33'(tf);
      end
      bm25_pkg::S_QM: begin
        mul_a = 33'(17'(k3_gain) + 17'd1);
        mul_b = 33'(qtf);
      end
      bm25_pkg::S_T1: begin
        mul_a = 33'(idf);
        mul_b = 33'(tfq);
      end
      bm25_pkg::S_T2: begin
        mul_a = 33'(t);
        mul_b = qtfq;
      end
      default: begin
        mul_a = 33'd0;
        mul_b = 33'd0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      bm25_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = bm25_pkg::S_LNORM;
        end
      end
      bm25_pkg::S_LNORM: state_next = bm25_pkg::S_LSQ;
      bm25_pkg::S_LSQ: begin
        if (log_done) begin
          state_next = second ? bm25_pkg::S_IDF : bm25_pkg::S_LNORM;
        end
      end
      bm25_pkg::S_IDF: state_next = bm25_pkg::S_KA;
      bm25_pkg::S_KA:  state_next = bm25_pkg::S_KB;
      bm25_pkg::S_KB:  state_next = bm25_pkg::S_KC;
      bm25_pkg::S_KC:  state_next = bm25_pkg::S_KD;
      bm25_pkg::S_KD:  state_next = bm25_pkg::S_KDIV;
      bm25_pkg::S_KDIV: begin
        if (div_done) begin
          state_next = bm25_pkg::S_TFM;
        end
      end
      bm25_pkg::S_TFM: begin
        state_next = (tf == 16'd0) ? bm25_pkg::S_QM : bm25_pkg::S_TDIV;
      end
      bm25_pkg::S_TDIV: begin
        if (div_done) begin
          state_next = bm25_pkg::S_QM;
        end
      end
      bm25_pkg::S_QM: begin
        state_next = qz ? bm25_pkg::S_T1 : bm25_pkg::S_QDIV;
      end
      bm25_pkg::S_QDIV: begin
        if (div_done) begin
          state_next = bm25_pkg::S_T1;
        end
      end
      bm25_pkg::S_T1: state_next = bm25_pkg::S_T2;
      bm25_pkg::S_T2: state_next = bm25_pkg::S_ACC;
      bm25_pkg::S_ACC: begin
        if (!last || out_load) begin
          state_next = bm25_pkg::S_IDLE;
        end
      end
      default: state_next = bm25_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != bm25_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bm25_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_docs       <= bm25_pkg::NUM_DOCS_RST;
      avg_doc_length <= bm25_pkg::AVG_LEN_RST;
      k1_gain        <= bm25_pkg::K1_RST;
      b_norm         <= bm25_pkg::B_RST;
      k3_gain        <= bm25_pkg::K3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bm25_pkg::REG_NUM_DOCS: num_docs       <= cfg_data[23:0];
        bm25_pkg::REG_AVG_LEN:  avg_doc_length <= cfg_data;
        bm25_pkg::REG_K1:       k1_gain        <= cfg_data[13:0];
        bm25_pkg::REG_B:        b_norm         <= cfg_data[12:0];
        bm25_pkg::REG_K3:       k3_gain        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bm25_pkg::S_IDLE: begin
        tf     <= term_freq;
        df     <= df_in;
        qtf    <= query_term_freq;
        dl     <= doc_length;
        last   <= last_term;
        second <= 1'b0;
        lv     <= 26'({num_docs, 1'b0}) + 26'd2;
      end
      bm25_pkg::S_LNORM: begin
        lexp <= lv_msb;
        lm   <= 31'(lv) << (5'd30 - lv_msb);
        frac <= 20'd0;
        cnt  <= 6'd0;
      end
      bm25_pkg::S_LSQ: begin
        lm   <= sq_top ? sq[31:1] : sq[30:0];
        frac <= frac_next;
        cnt  <= cnt + 6'd1;
        if (log_done) begin
          if (second) begin
            lb <= {lexp, frac_next};
          end else begin
            la     <= {lexp, frac_next};
            second <= 1'b1;
            lv     <= 26'({df, 1'b0}) + 26'd1;
          end
        end
      end
      bm25_pkg::S_IDF: begin
        idf <= (la > lb) ? mul_p[56:32] : 25'd0;
      end
      bm25_pkg::S_KA: begin
        s <= 46'(mul_p[44:0]);
      end
      bm25_pkg::S_KB: begin
        s <= s + 46'({mul_p[36:0], 8'd0});
      end
      bm25_pkg::S_KC: begin
        dvd <= 64'(mul_p[27:0]);
      end
      bm25_pkg::S_KD: begin
        dvd <= (dvd << 32) + 64'(mul_p[45:0]);
        dsr <= 53'({avg_e, 8'd0});
        rem <= 53'd0;
        cnt <= 6'd0;
      end
      bm25_pkg::S_KDIV, bm25_pkg::S_TDIV, bm25_pkg::S_QDIV: begin
        rem <= div_ge ? div_diff[52:0] : rem_sh[52:0];
        dvd <= {dvd[62:0], div_ge};
        cnt <= cnt + 6'd1;
      end
      bm25_pkg::S_TFM: begin
        dsr <= dvd[52:0] + 53'({tf, 16'd0});
        dvd <= 64'({mul_p[30:0], 20'd0});
        rem <= 53'd0;
        cnt <= 6'd0;
        if (tf == 16'd0) begin
          tfq <= 19'd0;
        end
      end
      bm25_pkg::S_QM: begin
        if (tf != 16'd0) begin
          tfq <= dvd[18:0];
        end
        dsr <= 53'(k3_gain) + 53'(qtf);
        dvd <= 64'({mul_p[32:0], 16'd0});
        rem <= 53'd0;
        cnt <= 6'd0;
      end
      bm25_pkg::S_T1: begin
        t    <= mul_p[43:20];
        qtfq <= qz ? 33'd0 : dvd[32:0];
      end
      bm25_pkg::S_T2: begin
        term <= 49'(mul_p[56:0] >> TERM_SHIFT);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_sum   <= 40'd0;
      sum_clipped <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (state == bm25_pkg::S_ACC && (!last || out_load)) begin
        if (out_load) begin
          score_sum   <= 40'd0;
          sum_clipped <= 1'b0;
        end else if (term > 49'(room)) begin
          score_sum   <= bm25_pkg::SUM_MAX;
          sum_clipped <= 1'b1;
        end else begin
          score_sum <= score_sum + term[39:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (term > 49'(room)) begin
        score     <= bm25_pkg::SUM_MAX;
        saturated <= 1'b1;
      end else begin
        score     <= score_sum + term[39:0];
        saturated <= sum_clipped;
      end
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block accepted a transfer and did not go busy");

  a_sat_score_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (score == bm25_pkg::SUM_MAX))
    else $error("saturated result without a full-scale score");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == bm25_pkg::S_ACC && $past(last)))
    else $error("result raised outside the final term");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (score_sum == 40'd0 && !sum_clipped))
    else $error("accumulator not cleared after a document");

endmodule
`default_nettype wire

FILE: dv/tb_bm25_document_scorer_top.sv
// Self-checking testbench for the BM25 document scorer with its own score predictor.
module tb_bm25_document_scorer_top;

  localparam int SCORE_FRAC_BITS = 16;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 3000;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [15:0] tf;
    logic [23:0] df;
    logic [15:0] qtf;
    logic [23:0] dl;
    logic        last;
  } term_t;

  typedef struct packed {
    logic [39:0] score;
    logic        sat;
  } doc_score_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] term_freq;
  logic [23:0] doc_freq;
  logic [15:0] query_term_freq;
  logic [23:0] doc_length;
  logic        last_term;
  logic        out_valid;
  logic        out_stall;
  logic [39:0] score;
  logic        saturated;

  bm25_document_scorer_top #(.SCORE_FRAC_BITS(SCORE_FRAC_BITS)) i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .term_freq(term_freq), .doc_freq(doc_freq),
    .query_term_freq(query_term_freq), .doc_length(doc_length), .last_term(last_term),
    .out_valid(out_valid), .out_stall(out_stall), .score(score), .saturated(saturated)
  );

  doc_score_t pending_scores[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit gaps_on = 1;
  bit hold_req = 0;

  logic [63:0] num_docs, avg_len, k1, b_val, k3;
  logic [63:0] acc_sum;
  logic        acc_clip;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] log2_q20(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] frac;
    int e;
    if (v == 0) v = 1;
    e = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    frac = 0;
    for (int i = 0; i < bm25_pkg::LOG_FRAC; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << bm25_pkg::LOG_FRAC) | frac;
  endfunction

  function automatic void score_term(input term_t t);
    logic [63:0] avg, b, df, tf, qtf, dl, la, lb, idf, k, den, tfq, qtfq, term_val;
    doc_score_t res;
    avg = (avg_len == 0) ? 64'd1 : avg_len;
    b = (b_val > 64'(bm25_pkg::B_ONE)) ? 64'(bm25_pkg::B_ONE) : b_val;
    tf = 64'(t.tf);
    qtf = 64'(t.qtf);
    dl = 64'(t.dl);
    df = 64'(t.df);
    if (df > num_docs) df = num_docs;
    la = log2_q20(2 * num_docs + 2);
    lb = log2_q20(2 * df + 1);
    idf = (la > lb) ? (((la - lb) * 64'(bm25_pkg::LN2_Q32)) >> 32) : 64'd0;
    k = (k1 * ((64'(bm25_pkg::B_ONE) - b) * avg + b * dl * 256)) / (avg << 8);
    if (tf == 0) begin
      tfq = 0;
    end else begin
      den = k + (tf << 16);
      tfq = (((k1 + 64'(bm25_pkg::K1_ONE)) * tf * 16) << 16) / den;
    end
    if (k3 + qtf == 0) begin
      qtfq = 0;
    end else begin
      qtfq = (((k3 + 1) * qtf) << 16) / (k3 + qtf);
    end
    term_val = (((idf * tfq) >> bm25_pkg::LOG_FRAC) * qtfq) >> (32 - SCORE_FRAC_BITS);
    if (term_val > 64'(bm25_pkg::SUM_MAX) - acc_sum) begin
      acc_sum = 64'(bm25_pkg::SUM_MAX);
      acc_clip = 1;
    end else begin
      acc_sum = acc_sum + term_val;
    end
    if (t.last) begin
      res.score = acc_sum[39:0];
      res.sat = acc_clip;
      pending_scores.push_back(res);
      acc_sum = 0;
      acc_clip = 0;
    end
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      bm25_pkg::REG_NUM_DOCS: num_docs = 64'(data[23:0]);
      bm25_pkg::REG_AVG_LEN:  avg_len = 64'(data);
      bm25_pkg::REG_K1:       k1 = 64'(data[13:0]);
      bm25_pkg::REG_B:        b_val = 64'(data[12:0]);
      bm25_pkg::REG_K3:       k3 = 64'(data[15:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] n, input logic [31:0] a, input logic [31:0] g1,
                           input logic [31:0] bn, input logic [31:0] g3);
    write_reg(bm25_pkg::REG_NUM_DOCS, n);
    write_reg(bm25_pkg::REG_AVG_LEN, a);
    write_reg(bm25_pkg::REG_K1, g1);
    write_reg(bm25_pkg::REG_B, bn);
    write_reg(bm25_pkg::REG_K3, g3);
  endtask

  task automatic send_term(input term_t t);
    int gap;
    bit ok;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 4);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    term_freq <= t.tf;
    doc_freq <= t.df;
    query_term_freq <= t.qtf;
    doc_length <= t.dl;
    last_term <= t.last;
    forever begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
      if (ok) break;
    end
    if (burst_left > 0) burst_left--;
    score_term(t);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val(input int w);
    logic [31:0] mask;
    mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 1);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return mask;
      2: return $urandom_range(1, 16);
      default: return $urandom & mask;
    endcase
  endfunction

  function automatic term_t rand_term(input logic last);
    term_t t;
    t.tf = 16'(rand_val(16));
    t.df = ($urandom_range(0, 3) == 0) ? 24'(rand_val(24)) :
           24'($urandom_range(0, 32'(num_docs)));
    t.qtf = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8)) : 16'(rand_val(16));
    t.dl = 24'(rand_val(24));
    t.last = last;
    return t;
  endfunction

  task automatic send_docs(input int n_terms);
    int left;
    int len;
    left = n_terms;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_term(rand_term(i == len - 1));
      left -= len;
    end
  endtask

  task automatic test_directed();
    term_t t;
    send_term('{16'd0, 24'd0, 16'd1, 24'd100, 1'b1});
    send_term('{16'hFFFF, 24'd0, 16'hFFFF, 24'hFF_FFFF, 1'b1});
    send_term('{16'd3, 24'hFF_FFFF, 16'd2, 24'd0, 1'b1});
    send_term('{16'd1, 24'd1, 16'd0, 24'd256, 1'b1});
    send_term('{16'd7, 24'd0, 16'd1, 24'd50, 1'b0});
    send_term('{16'd2, 24'd1, 16'd3, 24'd50, 1'b0});
    send_term('{16'd9, 24'd5, 16'd1, 24'd50, 1'b1});
    wait_idle();
    write_all(32'd1000, 32'd25600, 32'd6144, 32'd3072, 32'd0);
    send_term('{16'd4, 24'd10, 16'd0, 24'd80, 1'b1});
    send_term('{16'd4, 24'd10, 16'd1, 24'd80, 1'b0});
    send_term('{16'd0, 24'd2000, 16'd0, 24'd0, 1'b1});
    for (int i = 0; i < 8; i++) begin
      t = rand_term(i[0]);
      send_term(t);
    end
    wait_idle();
  endtask

  task automatic test_saturation();
    write_all(32'hFF_FFFF, 32'd256, 32'd16383, 32'd0, 32'd65535);
    for (int i = 0; i < 8; i++) send_term('{16'hFFFF, 24'd0, 16'hFFFF, 24'd1, i == 7});
    send_term('{16'd1, 24'd3, 16'd1, 24'd1, 1'b1});
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_docs(12);
    wait_idle();
    write_all(32'hFF_FFFF, 32'hFFFF_FFFF, 32'd16383, 32'd4096, 32'd65535);
    send_docs(12);
    wait_idle();
    write_all(32'hFF00_03E8, 32'd1, 32'd1, 32'd8191, 32'd1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_docs(12);
    wait_idle();
  endtask

  task automatic test_backpressure();
    write_all(32'd5000, 32'd12800, 32'd6144, 32'd3072, 32'd500);
    gaps_on = 0;
    hold_req = 1;
    for (int i = 0; i < 20; i++) send_term(rand_term(1'b1));
    gaps_on = 1;
    wait_idle();
  endtask

  task automatic test_random_documents();
    for (int r = 0; r < 7; r++) begin
      write_all(rand_val(24), rand_val(32), rand_val(14),
                ($urandom_range(0, 3) == 0) ? rand_val(13) : $urandom_range(0, 4096),
                rand_val(16));
      gaps_on = (r != 3);
      send_docs(90);
      wait_idle();
    end
    gaps_on = 1;
  endtask

  initial begin
    int cyc;
    out_stall = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_stall <= 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else begin
        case ((cyc / 400) % 4)
          0: out_stall <= 0;
          1: out_stall <= $urandom_range(0, 1);
          2: out_stall <= (cyc % 7) < 3;
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  always @(negedge clk) begin
    doc_score_t exp_score;
    if (!rst && out_valid && !out_stall) begin
      if (pending_scores.size() == 0) begin
        $error("unexpected result: score %0h saturated %0b", score, saturated);
        errors++;
      end else begin
        exp_score = pending_scores.pop_front();
        if (score !== exp_score.score) begin
          $error("score: expected %0h, actual %0h", exp_score.score, score);
          errors++;
        end
        if (saturated !== exp_score.sat) begin
          $error("saturated: expected %0b, actual %0b", exp_score.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = bm25_pkg::REG_NUM_DOCS;
    cfg_data = 0;
    in_valid = 0;
    term_freq = 0;
    doc_freq = 0;
    query_term_freq = 0;
    doc_length = 0;
    last_term = 0;
    num_docs = 64'(bm25_pkg::NUM_DOCS_RST);
    avg_len = 64'(bm25_pkg::AVG_LEN_RST);
    k1 = 64'(bm25_pkg::K1_RST);
    b_val = 64'(bm25_pkg::B_RST);
    k3 = 64'(bm25_pkg::K3_RST);
    acc_sum = 0;
    acc_clip = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_config_extremes();
    test_backpressure();
    test_random_documents();
    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
